@@ src/rrhit_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rrhit_pkg;

  // Default coordinate width; the top level overrides it through COORD_BITS.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Configuration register index width (six registers).
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_WIDTH          = 3'd0,
    REG_RECT_HEIGHT         = 3'd1,
    REG_RADIUS_TOP_LEFT     = 3'd2,
    REG_RADIUS_TOP_RIGHT    = 3'd3,
    REG_RADIUS_BOTTOM_RIGHT = 3'd4,
    REG_RADIUS_BOTTOM_LEFT  = 3'd5
  } cfg_reg_e;

  // Per-word control that travels beside the arc operands.
  typedef struct packed {
    logic valid;    // word present in this stage
    logic outside;  // point left the closed bounding box
    logic arc;      // a corner quadrant holds the point, arc compare decides
  } flags_t;

endpackage

`default_nettype wire

@@ src/rrhit_map.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: move the point to doubled corner-origin coordinates.
// Stage 2: bounding box test, corner priority, arc operands.
module rrhit_map #(
  parameter int unsigned COORD_BITS = rrhit_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic        [COORD_BITS-1:0] width_i,
  input  wire logic        [COORD_BITS-1:0] height_i,
  input  wire logic        [COORD_BITS-1:0] rad_tl_i,
  input  wire logic        [COORD_BITS-1:0] rad_tr_i,
  input  wire logic        [COORD_BITS-1:0] rad_br_i,
  input  wire logic        [COORD_BITS-1:0] rad_bl_i,
  output rrhit_pkg::flags_t                 flags_o,
  output logic             [COORD_BITS:0]   a_o,
  output logic             [COORD_BITS:0]   b_o,
  output logic             [COORD_BITS:0]   c_o
);

  localparam int unsigned PW = COORD_BITS + 2;  // doubled point
  localparam int unsigned DW = COORD_BITS + 3;  // corner differences
  localparam int unsigned MW = COORD_BITS + 1;  // arc magnitudes

  // ---------------- stage 1 ----------------
  logic                 s1_valid_q;
  logic signed [PW-1:0] px_d, py_d, px_q, py_q;

  assign px_d = $signed({point_x_i[COORD_BITS-1], point_x_i, 1'b0})
              + $signed({2'b00, width_i});
  assign py_d = $signed({point_y_i[COORD_BITS-1], point_y_i, 1'b0})
              + $signed({2'b00, height_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
  end

  // ---------------- stage 2 ----------------
  logic signed [DW-1:0] px_e, py_e, w2, h2;
  logic signed [DW-1:0] r_tl, r_tr, r_br, r_bl;
  logic signed [DW-1:0] tl_x, tl_y, tr_x, tr_y, br_x, br_y, bl_x, bl_y;
  logic                 outside;
  logic                 hit;
  logic [MW-1:0]        a_d, b_d, c_d;
  rrhit_pkg::flags_t    flags_d, flags_q;
  logic [MW-1:0]        a_q, b_q, c_q;

  assign px_e = $signed({px_q[PW-1], px_q});
  assign py_e = $signed({py_q[PW-1], py_q});
  assign w2   = $signed({2'b00, width_i, 1'b0});
  assign h2   = $signed({2'b00, height_i, 1'b0});
  assign r_tl = $signed({2'b00, rad_tl_i, 1'b0});
  assign r_tr = $signed({2'b00, rad_tr_i, 1'b0});
  assign r_br = $signed({2'b00, rad_br_i, 1'b0});
  assign r_bl = $signed({2'b00, rad_bl_i, 1'b0});

  // Distances into each corner quadrant; positive means strictly inside it.
  assign tl_x = r_tl - px_e;
  assign tl_y = r_tl - py_e;
  assign tr_x = px_e - (w2 - r_tr);
  assign tr_y = r_tr - py_e;
  assign br_x = px_e - (w2 - r_br);
  assign br_y = py_e - (h2 - r_br);
  assign bl_x = r_bl - px_e;
  assign bl_y = py_e - (h2 - r_bl);

  assign outside = (px_e < 0) || (py_e < 0) || (px_e > w2) || (py_e > h2);

  always_comb begin
    hit = 1'b1;
    a_d = tl_x[MW-1:0];
    b_d = tl_y[MW-1:0];
    c_d = {rad_tl_i, 1'b0};
    if ((tl_x > 0) && (tl_y > 0)) begin
      a_d = tl_x[MW-1:0];
      b_d = tl_y[MW-1:0];
      c_d = {rad_tl_i, 1'b0};
    end else if ((tr_x > 0) && (tr_y > 0)) begin
      a_d = tr_x[MW-1:0];
      b_d = tr_y[MW-1:0];
      c_d = {rad_tr_i, 1'b0};
    end else if ((br_x > 0) && (br_y > 0)) begin
      a_d = br_x[MW-1:0];
      b_d = br_y[MW-1:0];
      c_d = {rad_br_i, 1'b0};
    end else if ((bl_x > 0) && (bl_y > 0)) begin
      a_d = bl_x[MW-1:0];
      b_d = bl_y[MW-1:0];
      c_d = {rad_bl_i, 1'b0};
    end else begin
      hit = 1'b0;
    end
  end

  assign flags_d.valid   = s1_valid_q;
  assign flags_d.outside = outside;
  assign flags_d.arc     = !outside && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
  end

  assign flags_o = flags_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign c_o     = c_q;

endmodule

`default_nettype wire

@@ src/rrhit_arc.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Arc compare b*b <= (c-a)*(c+a) over three stages: operands, products, verdict.
module rrhit_arc #(
  parameter int unsigned COORD_BITS = rrhit_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rrhit_pkg::flags_t     flags_i,
  input  wire logic [COORD_BITS:0]   a_i,
  input  wire logic [COORD_BITS:0]   b_i,
  input  wire logic [COORD_BITS:0]   c_i,
  output logic                       res_valid_o,
  output logic                       inside_o
);

  localparam int unsigned MW = COORD_BITS + 1;

  // ---------------- stage 3 ----------------
  rrhit_pkg::flags_t s3_flags_q;
  logic [MW-1:0]     u_d, u_q, s3_b_q;
  logic [MW:0]       v_d, v_q;

  assign u_d = c_i - a_i;
  assign v_d = {1'b0, c_i} + {1'b0, a_i};

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    v_q    <= v_d;
    s3_b_q <= b_i;
  end

  // ---------------- stage 4 ----------------
  rrhit_pkg::flags_t s4_flags_q;
  logic [2*MW-1:0]   bb_d, bb_q;
  logic [2*MW:0]     uv_d, uv_q;

  assign bb_d = {{MW{1'b0}}, s3_b_q} * {{MW{1'b0}}, s3_b_q};
  assign uv_d = {{(MW+1){1'b0}}, u_q} * {{MW{1'b0}}, v_q};

  always_ff @(posedge clk_i) begin
    bb_q <= bb_d;
    uv_q <= uv_d;
  end

  // ---------------- stage 5 ----------------
  logic inside_d, inside_q, res_valid_q;

  always_comb begin
    if (s4_flags_q.outside) begin
      inside_d = 1'b0;
    end else if (s4_flags_q.arc) begin
      inside_d = ({1'b0, bb_q} <= uv_q);
    end else begin
      inside_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_flags_q  <= '0;
      s4_flags_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      s3_flags_q  <= flags_i;
      s4_flags_q  <= s3_flags_q;
      res_valid_q <= s4_flags_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  assign res_valid_o = res_valid_q;
  assign inside_o    = inside_q;

  // ---------------- checks ----------------
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_flags_q.valid |-> !(s3_flags_q.outside && s3_flags_q.arc))
    else $error("outside and arc both set");

  a_arc_operands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_flags_q.valid && s3_flags_q.arc) |-> ({1'b0, u_q} <= v_q))
    else $error("arc operand c-a exceeds c+a");

  a_outside_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_flags_q.valid && s4_flags_q.outside) |=> (res_valid_o && !inside_o))
    else $error("point outside the box reported inside");

  a_no_corner_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_flags_q.valid && !s4_flags_q.outside && !s4_flags_q.arc)
      |=> (res_valid_o && inside_o))
    else $error("point clear of all corners reported outside");

endmodule

`default_nettype wire

@@ src/rounded_rect_point_hit_test.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Rounded rectangle point hit test.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  --------------------------------
//   point     in         start (busy always 0)  point_x_i, point_y_i (signed)
//   result    out        res_valid_o strobe     inside_res_o
//   config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// Pipeline: one word enters per clock; each result passes two mapping
//   stages, an operand stage, a multiply stage and a verdict register.
//   Sustained rate is one point per cycle.
// Reset: rst_ni clears the stage valid bits and all six geometry registers.
// Stalls: none. busy stays low and the receiver takes each result in the
//   single cycle its strobe is high.
// Config: write only while no word is in flight; the stages read the
//   geometry registers directly rather than carrying a copy per word.
//
// The point is moved to doubled corner-origin units (2*p + size) so the
// half extents stay exact. Outside the closed box gives 0; otherwise the
// first corner (top-left, top-right, bottom-right, bottom-left) whose
// quadrant strictly holds the point decides with b*b <= (c-a)*(c+a), where
// a and b are the distances into the quadrant and c the doubled radius.
module rounded_rect_point_hit_test #(
  parameter int unsigned COORD_BITS = rrhit_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_BITS-1:0]        point_x_i,
  input  wire logic signed [COORD_BITS-1:0]        point_y_i,
  output logic                                     res_valid_o,
  output logic                                     inside_res_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [rrhit_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]               cfg_data_i
);

  // Geometry registers.
  logic [COORD_BITS-1:0] rect_width_q, rect_height_q;
  logic [COORD_BITS-1:0] rad_tl_q, rad_tr_q, rad_br_q, rad_bl_q;

  // Decode the write; indexes past the list fall through and are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_width_q  <= '0;
      rect_height_q <= '0;
      rad_tl_q      <= '0;
      rad_tr_q      <= '0;
      rad_br_q      <= '0;
      rad_bl_q      <= '0;
    end else if (cfg_we_i) begin
      case (rrhit_pkg::cfg_reg_e'(cfg_idx_i))
        rrhit_pkg::REG_RECT_WIDTH:          rect_width_q  <= cfg_data_i;
        rrhit_pkg::REG_RECT_HEIGHT:         rect_height_q <= cfg_data_i;
        rrhit_pkg::REG_RADIUS_TOP_LEFT:     rad_tl_q      <= cfg_data_i;
        rrhit_pkg::REG_RADIUS_TOP_RIGHT:    rad_tr_q      <= cfg_data_i;
        rrhit_pkg::REG_RADIUS_BOTTOM_RIGHT: rad_br_q      <= cfg_data_i;
        rrhit_pkg::REG_RADIUS_BOTTOM_LEFT:  rad_bl_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The pipeline never holds off a word.
  assign busy = 1'b0;

  rrhit_pkg::flags_t     map_flags;
  logic [COORD_BITS:0]   map_a, map_b, map_c;

  // Map stages: corner-origin shift, then box test and corner pick.
  rrhit_map #(
    .COORD_BITS(COORD_BITS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (start && !busy),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .width_i   (rect_width_q),
    .height_i  (rect_height_q),
    .rad_tl_i  (rad_tl_q),
    .rad_tr_i  (rad_tr_q),
    .rad_br_i  (rad_br_q),
    .rad_bl_i  (rad_bl_q),
    .flags_o   (map_flags),
    .a_o       (map_a),
    .b_o       (map_b),
    .c_o       (map_c)
  );

  // Arc stages: operands, squared terms, verdict.
  rrhit_arc #(
    .COORD_BITS(COORD_BITS)
  ) u_arc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flags_i     (map_flags),
    .a_i         (map_a),
    .b_i         (map_b),
    .c_i         (map_c),
    .res_valid_o (res_valid_o),
    .inside_o    (inside_res_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_rounded_rect_point_hit_test.sv @@
`timescale 1ns / 1ps

module tb_rounded_rect_point_hit_test;

  localparam int unsigned CW = 16;
  localparam int unsigned CLK_HALF_NS = 4;
  localparam int unsigned RESET_CYCLES = 5;
  // Five pipeline stages; give the tail a few extra cycles.
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned GAP_PERCENT = 33;
  localparam int unsigned RANDOM_PHASES = 11;
  localparam int unsigned WORDS_PER_PHASE = 60;

  // Indexes past the last geometry register; writes to them must be dropped.
  localparam logic [rrhit_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [rrhit_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic signed [CW-1:0]            point_x_i;
  logic signed [CW-1:0]            point_y_i;
  logic                            res_valid_o;
  logic                            inside_res_o;
  logic                            cfg_we_i;
  logic [rrhit_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CW-1:0]                   cfg_data_i;

  // Shadow copy of the geometry registers, updated on each write.
  logic [CW-1:0] geom_width;
  logic [CW-1:0] geom_height;
  logic [CW-1:0] geom_r_tl;
  logic [CW-1:0] geom_r_tr;
  logic [CW-1:0] geom_r_br;
  logic [CW-1:0] geom_r_bl;

  // Hit verdicts still owed by the block, oldest first.
  bit expected_inside_q[$];

  int unsigned error_count;
  int unsigned cycle_count;
  bit          gaps_on;
  logic        busy_smp;

  rounded_rect_point_hit_test #(
    .COORD_BITS(CW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .res_valid_o (res_valid_o),
    .inside_res_o(inside_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time,
               expected_inside_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // b*b <= (c-a)*(c+a) is a*a + b*b <= c*c without a square root; all terms
  // are non-negative and stay far below 64 bits.
  function automatic bit arc_holds(longint a, longint b, longint c);
    return (b * b) <= ((c - a) * (c + a));
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Work in doubled corner-origin units so half sizes stay integral.
  function automatic bit predict_inside(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    longint w2, h2, px, py, r, dx, dy;
    w2 = 2 * longint'(geom_width);
    h2 = 2 * longint'(geom_height);
    px = 2 * longint'(x) + longint'(geom_width);
    py = 2 * longint'(y) + longint'(geom_height);
    if (px < 0 || py < 0 || px > w2 || py > h2) return 1'b0;
    // Corners in fixed order; the first whose quadrant strictly holds the
    // point decides.
    r = 2 * longint'(geom_r_tl);
    dx = px - r;
    dy = py - r;
    if (dx < 0 && dy < 0) return arc_holds(magnitude(dx), magnitude(dy), r);
    r = 2 * longint'(geom_r_tr);
    dx = px - (w2 - r);
    dy = py - r;
    if (dx > 0 && dy < 0) return arc_holds(magnitude(dx), magnitude(dy), r);
    r = 2 * longint'(geom_r_br);
    dx = px - (w2 - r);
    dy = py - (h2 - r);
    if (dx > 0 && dy > 0) return arc_holds(magnitude(dx), magnitude(dy), r);
    r = 2 * longint'(geom_r_bl);
    dx = px - r;
    dy = py - (h2 - r);
    if (dx < 0 && dy > 0) return arc_holds(magnitude(dx), magnitude(dy), r);
    return 1'b1;
  endfunction

  // Sample outputs mid-cycle, where they are settled; a strobe seen here is
  // taken at the next rising edge. busy is captured for the send task.
  always @(negedge clk_i) begin
    busy_smp <= busy;
    if (rst_ni && res_valid_o) begin
      if (expected_inside_q.size() == 0) begin
        $display("%0t: verdict with nothing pending: expected none, actual %b",
                 $time, inside_res_o);
        error_count <= error_count + 1;
      end else begin
        if (inside_res_o !== expected_inside_q[0]) begin
          $display("%0t: inside mismatch: expected %b, actual %b", $time,
                   expected_inside_q[0], inside_res_o);
          error_count <= error_count + 1;
        end
        void'(expected_inside_q.pop_front());
      end
    end
  end

  // Offer one word; hold it until the block takes it, then queue its verdict.
  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < GAP_PERCENT) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    do @(posedge clk_i); while (busy_smp);
    expected_inside_q.push_back(predict_inside(x, y));
  endtask

  // Drop start and hold until every owed verdict has come back.
  task automatic quiesce();
    start <= 1'b0;
    while (expected_inside_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rrhit_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      rrhit_pkg::REG_RECT_WIDTH:          geom_width = data;
      rrhit_pkg::REG_RECT_HEIGHT:         geom_height = data;
      rrhit_pkg::REG_RADIUS_TOP_LEFT:     geom_r_tl = data;
      rrhit_pkg::REG_RADIUS_TOP_RIGHT:    geom_r_tr = data;
      rrhit_pkg::REG_RADIUS_BOTTOM_RIGHT: geom_r_br = data;
      rrhit_pkg::REG_RADIUS_BOTTOM_LEFT:  geom_r_bl = data;
      default: ;
    endcase
  endtask

  // Load a full geometry with the pipeline empty.
  task automatic set_geometry(input logic [CW-1:0] w, input logic [CW-1:0] h,
                              input logic [CW-1:0] tl, input logic [CW-1:0] tr,
                              input logic [CW-1:0] br, input logic [CW-1:0] bl);
    quiesce();
    write_reg(rrhit_pkg::REG_RECT_WIDTH, w);
    write_reg(rrhit_pkg::REG_RECT_HEIGHT, h);
    write_reg(rrhit_pkg::REG_RADIUS_TOP_LEFT, tl);
    write_reg(rrhit_pkg::REG_RADIUS_TOP_RIGHT, tr);
    write_reg(rrhit_pkg::REG_RADIUS_BOTTOM_RIGHT, br);
    write_reg(rrhit_pkg::REG_RADIUS_BOTTOM_LEFT, bl);
    cfg_we_i <= 1'b0;
  endtask

  // Coordinate spread a little past the box on both sides, clamped to 16 bits.
  function automatic logic signed [CW-1:0] near_coord(logic [CW-1:0] size);
    int half, v;
    half = int'(size) / 2 + 24;
    v = int'($urandom_range(0, 2 * half)) - half;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CW-1:0];
  endfunction

  // Registers straight out of reset: a zero-size box at the center.
  task automatic test_reset_geometry();
    send_point(16'sd0, 16'sd0);
    send_point(16'sd1, 16'sd0);
    send_point(-16'sd1, 16'sd0);
  endtask

  // Points on the box edges count as inside, points just past them do not; odd width included.
  task automatic test_box_edges();
    set_geometry(16'd101, 16'd60, 16'd0, 16'd0, 16'd0, 16'd0);
    send_point(16'sd50, 16'sd30);
    send_point(-16'sd50, -16'sd30);
    send_point(16'sd51, 16'sd0);
    send_point(-16'sd51, 16'sd0);
    send_point(16'sd0, 16'sd31);
  endtask

  // One point exactly on each arc, one just outside it, four distinct radii.
  task automatic test_corner_arcs();
    set_geometry(16'd320, 16'd200, 16'd40, 16'd25, 16'd65, 16'd10);
    send_point(-16'sd144, -16'sd92);
    send_point(-16'sd145, -16'sd92);
    send_point(16'sd150, -16'sd95);
    send_point(16'sd151, -16'sd95);
    send_point(16'sd134, 16'sd87);
    send_point(16'sd134, 16'sd88);
    send_point(-16'sd156, 16'sd98);
    send_point(-16'sd157, 16'sd98);
  endtask

  // Radii far past the sides: the first quadrant that holds the point wins.
  task automatic test_oversized_radii();
    set_geometry(16'd100, 16'd100, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_point(16'sd0, 16'sd0);
    send_point(16'sd50, 16'sd50);
    send_point(-16'sd50, 16'sd0);
  endtask

  // Zero width: only the center column can pass the box test.
  task automatic test_degenerate_box();
    set_geometry(16'd0, 16'd50, 16'd3, 16'd3, 16'd3, 16'd3);
    send_point(16'sd0, 16'sd0);
    send_point(16'sd0, 16'sd25);
    send_point(16'sd0, -16'sd26);
  endtask

  // Largest box against the extreme coordinates.
  task automatic test_extreme_fields();
    set_geometry(16'hffff, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd0);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, 16'sd0);
    send_point(-16'sd32767, -16'sd32767);
  endtask

  // Writes to unused indexes must leave the geometry untouched.
  task automatic test_spare_indexes();
    quiesce();
    write_reg(REG_SPARE_6, 16'hffff);
    write_reg(REG_SPARE_7, 16'h0001);
    cfg_we_i <= 1'b0;
    send_point(16'sd32767, -16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
  endtask

  // Random geometries, most small with radii inside the sides; some with
  // full-range or oversized values. Points mostly hug the box.
  task automatic test_random_points();
    int unsigned mode, lim;
    logic [CW-1:0] w, h;
    logic [CW-1:0] rad[4];
    logic signed [CW-1:0] x, y;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = (phase < 2) ? phase : $urandom_range(2, 11);
      if (mode == 0) begin
        w = CW'($urandom);
        h = CW'($urandom);
        foreach (rad[i]) rad[i] = CW'($urandom);
      end else if (mode == 1) begin
        w = 16'hffff;
        h = 16'hffff;
        foreach (rad[i]) rad[i] = CW'($urandom_range(0, 32767));
      end else begin
        w = CW'($urandom_range(0, 600));
        h = CW'($urandom_range(0, 600));
        lim = 32'(((w < h) ? w : h) / 2);
        foreach (rad[i]) begin
          case ($urandom_range(0, 9))
            0, 1:    rad[i] = 16'd0;
            2:       rad[i] = CW'($urandom_range(0, 1000));
            default: rad[i] = CW'($urandom_range(0, lim));
          endcase
        end
      end
      set_geometry(w, h, rad[0], rad[1], rad[2], rad[3]);
      // One phase runs back to back with no gaps at all.
      gaps_on = (phase != 5);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          x = CW'($urandom);
          y = CW'($urandom);
        end else begin
          x = near_coord(w);
          y = near_coord(h);
        end
        send_point(x, y);
        // Halfway through one phase, hold off until the pipeline is empty.
        if (phase == 7 && n == WORDS_PER_PHASE / 2) quiesce();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    geom_width = '0;
    geom_height = '0;
    geom_r_tl = '0;
    geom_r_tr = '0;
    geom_r_br = '0;
    geom_r_bl = '0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    point_x_i <= '0;
    point_y_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= rrhit_pkg::REG_RECT_WIDTH;
    cfg_data_i <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_box_edges();
    test_corner_arcs();
    test_oversized_radii();
    test_degenerate_box();
    test_extreme_fields();
    test_spare_indexes();
    test_random_points();

    // Drain, then let the tail run to catch stray strobes.
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_inside_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
